### rtl/tppc_pkg.sv
`timescale 1ns / 1ps
package tppc_pkg;

  // Frame layout (byte offsets in wire order)
  localparam int unsigned OFFSET_W       = 6;
  localparam logic [OFFSET_W-1:0] OFS_ETYPE_HI = 6'd12;
  localparam logic [OFFSET_W-1:0] OFS_ETYPE_LO = 6'd13;
  localparam logic [OFFSET_W-1:0] OFS_PROTO    = 6'd23;
  localparam logic [OFFSET_W-1:0] OFS_DPORT_HI = 6'd36;
  localparam logic [OFFSET_W-1:0] OFS_DPORT_LO = 6'd37;
  localparam logic [OFFSET_W-1:0] MIN_FRAME_LEN = 6'd54;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] PROTO_TCP     = 8'h06;

  localparam int unsigned COUNT_W = 64;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned VALUE_W = 8;

  // Command queue between parser and table engine
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Result kinds and write status codes
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_WRITE = 1'b1;
  localparam logic WSTAT_OK   = 1'b0;
  localparam logic WSTAT_FULL = 1'b1;

  // Function codes of an input word
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // One command for the table engine: a finished frame or a table write
  typedef struct packed {
    logic                is_write;
    logic                hdr_ok;
    logic [PORT_W-1:0]   port;
    logic [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

### rtl/tppc_front.sv
`timescale 1ns / 1ps
module tppc_front
  import tppc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               func,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic [PORT_W-1:0]  port_key,
  input  logic [VALUE_W-1:0] port_value,
  output logic               push,
  output cmd_t               push_cmd
);

  logic [OFFSET_W-1:0] byte_offset;
  logic [OFFSET_W-1:0] byte_offset_next;
  logic                ethertype_ok;
  logic                ethertype_ok_next;
  logic                protocol_ok;
  logic                protocol_ok_next;
  logic [PORT_W-1:0]   dest_port;
  logic [PORT_W-1:0]   dest_port_next;
  logic                is_byte;

  assign is_byte = accept && (func == FUNC_BYTE);

  // Track header fields at their fixed offsets
  always_comb begin
    ethertype_ok_next = ethertype_ok;
    protocol_ok_next  = protocol_ok;
    dest_port_next    = dest_port;
    unique case (byte_offset)
      OFS_ETYPE_HI: ethertype_ok_next = (data_byte == ETYPE_IPV4_HI);
      OFS_ETYPE_LO: ethertype_ok_next = ethertype_ok && (data_byte == ETYPE_IPV4_LO);
      OFS_PROTO:    protocol_ok_next  = (data_byte == PROTO_TCP);
      OFS_DPORT_HI: dest_port_next    = {data_byte, 8'h00};
      OFS_DPORT_LO: dest_port_next    = {dest_port[PORT_W-1:8], data_byte};
      default: ;
    endcase
    byte_offset_next = (byte_offset < MIN_FRAME_LEN) ? byte_offset + 1'b1 : byte_offset;
  end

  // Advance frame state; clear at the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      ethertype_ok <= 1'b0;
      protocol_ok  <= 1'b0;
      dest_port    <= '0;
    end else if (is_byte) begin
      if (last) begin
        byte_offset  <= '0;
        ethertype_ok <= 1'b0;
        protocol_ok  <= 1'b0;
        dest_port    <= '0;
      end else begin
        byte_offset  <= byte_offset_next;
        ethertype_ok <= ethertype_ok_next;
        protocol_ok  <= protocol_ok_next;
        dest_port    <= dest_port_next;
      end
    end
  end

  // Issue a command at end of frame or for a table write
  assign push = accept && ((func == FUNC_WRITE) || last);

  always_comb begin
    push_cmd.is_write = (func == FUNC_WRITE);
    push_cmd.hdr_ok   = (byte_offset_next >= MIN_FRAME_LEN) && ethertype_ok_next
                        && protocol_ok_next;
    push_cmd.port     = (func == FUNC_WRITE) ? port_key : dest_port_next;
    push_cmd.value    = port_value;
  end

endmodule

### rtl/tppc_queue.sv
`timescale 1ns / 1ps
module tppc_queue
  import tppc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

endmodule

### rtl/tppc_back.sv
`timescale 1ns / 1ps
module tppc_back
  import tppc_pkg::*;
#(
  parameter int unsigned PORT_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cmd_t               head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic               is_match,
  output logic [COUNT_W-1:0] total_count,
  output logic [COUNT_W-1:0] match_count,
  output logic [COUNT_W-1:0] other_count,
  output logic               write_status
);

  // Port table: one compare cell per entry
  logic [PORT_W-1:0]       tbl_port  [PORT_ENTRIES];
  logic [VALUE_W-1:0]      tbl_value [PORT_ENTRIES];
  logic [PORT_ENTRIES-1:0] tbl_valid;

  // Lookup stage
  logic                    a_valid;
  cmd_t                    a_cmd;
  logic [PORT_ENTRIES-1:0] a_hit;
  logic [PORT_ENTRIES-1:0] a_nz;
  logic [PORT_ENTRIES-1:0] a_free;
  logic                    a_adv;
  logic                    a_load;

  logic [PORT_ENTRIES-1:0] hit_now;
  logic [PORT_ENTRIES-1:0] nz_now;
  logic                    any_hit;
  logic                    any_free;
  logic                    frame_match;

  logic [COUNT_W-1:0] total_cnt;
  logic [COUNT_W-1:0] match_cnt;
  logic [COUNT_W-1:0] other_cnt;

  assign a_adv = a_valid && (!out_valid || !out_stall);
  // A write must land in the table before the next lookup samples it
  assign a_load = head_valid && (!a_valid || (a_adv && !a_cmd.is_write));
  assign pop    = a_load;

  // Compare the head port against every entry
  always_comb begin
    for (int i = 0; i < PORT_ENTRIES; i++) begin
      hit_now[i] = tbl_valid[i] && (tbl_port[i] == head_cmd.port);
      nz_now[i]  = (tbl_value[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  // Capture lookup vectors; lowest free slot is the lowest clear valid bit
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_cmd  <= head_cmd;
      a_hit  <= hit_now;
      a_nz   <= nz_now;
      a_free <= ~tbl_valid & (tbl_valid + PORT_ENTRIES'(1));
    end
  end

  assign any_hit     = |a_hit;
  assign any_free    = |a_free;
  assign frame_match = a_cmd.hdr_ok && (|(a_hit & a_nz));

  // Apply table writes: update in place, else insert at free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
    end else if (a_adv && a_cmd.is_write && !any_hit) begin
      tbl_valid <= tbl_valid | a_free;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PORT_ENTRIES; i++) begin
      if (a_adv && a_cmd.is_write) begin
        if (any_hit) begin
          if (a_hit[i]) begin
            tbl_value[i] <= a_cmd.value;
          end
        end else if (a_free[i]) begin
          tbl_port[i]  <= a_cmd.port;
          tbl_value[i] <= a_cmd.value;
        end
      end
    end
  end

  // Bump frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      total_cnt <= '0;
      match_cnt <= '0;
      other_cnt <= '0;
    end else if (a_adv && !a_cmd.is_write) begin
      total_cnt <= total_cnt + 1'b1;
      if (frame_match) begin
        match_cnt <= match_cnt + 1'b1;
      end else begin
        other_cnt <= other_cnt + 1'b1;
      end
    end
  end

  // Output register; counters only move when a new word loads it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      kind         <= a_cmd.is_write ? KIND_WRITE : KIND_FRAME;
      is_match     <= !a_cmd.is_write && frame_match;
      write_status <= (a_cmd.is_write && !any_hit && !any_free) ? WSTAT_FULL : WSTAT_OK;
    end
  end

  assign total_count = total_cnt;
  assign match_count = match_cnt;
  assign other_count = other_cnt;

  assert property (@(posedge clk) disable iff (rst)
    a_valid |-> $onehot0(a_hit))
    else $error("port present in more than one table entry");

  assert property (@(posedge clk) disable iff (rst)
    a_valid |-> ((a_hit & a_free) == '0))
    else $error("free slot also reported as hit");

  assert property (@(posedge clk) disable iff (rst)
    total_cnt == match_cnt + other_cnt)
    else $error("frame counters out of balance");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(total_cnt) && $stable(match_cnt))
    else $error("counters moved under a held result");

endmodule

### rtl/tcp_port_packet_classifier.sv
`timescale 1ns / 1ps
// A frame's last byte or a table write goes through the command queue, the lookup stage
// and the output register. One frame byte per cycle while the command queue is not full;
// a table write lands in the port table before the lookup stage takes the next command.
// Reset clears frame state, counters, the command queue and all table valid bits;
// table ports and values are not cleared.
module tcp_port_packet_classifier
  import tppc_pkg::*;
#(
  parameter int unsigned PORT_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic [PORT_W-1:0]  port_key,
  input  logic [VALUE_W-1:0] port_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic               is_match,
  output logic [COUNT_W-1:0] total_count,
  output logic [COUNT_W-1:0] match_count,
  output logic [COUNT_W-1:0] other_count,
  output logic               write_status
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  tppc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func),
    .data_byte  (data_byte),
    .last       (last),
    .port_key   (port_key),
    .port_value (port_value),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  tppc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  tppc_back #(
    .PORT_ENTRIES (PORT_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .is_match     (is_match),
    .total_count  (total_count),
    .match_count  (match_count),
    .other_count  (other_count),
    .write_status (write_status)
  );

endmodule
